// File: sv/crc16_frame_encoder_macros.svh
// Assertion helper macros for the frame encoder.
`ifndef CRC16_FRAME_ENCODER_MACROS_SVH
`define CRC16_FRAME_ENCODER_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define CFE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfe: same-cycle check failed");

// Next-cycle implication, off while reset is asserted
`define CFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfe: next-cycle check failed");

`endif

// File: sv/cfe_pkg.sv
// ============================================================================
// cfe_pkg
// Shared types, constants and the CRC-16 byte fold for the frame encoder.
// ============================================================================
package cfe_pkg;

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Register reset values
    localparam logic [7:0]  VERSION_RESET  = 8'h01;
    localparam logic [15:0] PREAMBLE_RESET = 16'hAA55;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_VERSION  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PREAMBLE = 1'd1;

    // Job queue depth default
    localparam int QUEUE_DEPTH_DEF = 4;

    // Byte positions within a frame job
    localparam int POS_W = 4;
    localparam logic [POS_W-1:0] POS_PRE_HI  = 4'd0;
    localparam logic [POS_W-1:0] POS_PRE_LO  = 4'd1;
    localparam logic [POS_W-1:0] POS_VERSION = 4'd2;
    localparam logic [POS_W-1:0] POS_TYPE    = 4'd3;
    localparam logic [POS_W-1:0] POS_SEQ     = 4'd4;
    localparam logic [POS_W-1:0] POS_LEN_HI  = 4'd5;
    localparam logic [POS_W-1:0] POS_DATA    = 4'd6;
    localparam logic [POS_W-1:0] POS_CRC_HI  = 4'd7;
    localparam logic [POS_W-1:0] POS_CRC_LO  = 4'd8;

    // Input command codes
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  type_code;
        logic [7:0]  seq_num;
        logic [15:0] frame_length;
        logic [7:0]  payload_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       run_last;
        logic       frame_end;
    } out_item_t;

    typedef enum logic {
        JOB_START = 1'b0,
        JOB_DATA  = 1'b1
    } job_kind_t;

    // One unit of work for the serializer
    typedef struct packed {
        job_kind_t   kind;
        logic        ends;       // CRC follows this job
        logic [15:0] preamble;
        logic [7:0]  version;
        logic [7:0]  type_code;
        logic [7:0]  seq_num;
        logic [15:0] frame_length;
        logic [7:0]  data;
    } job_t;

    // Fold one byte into the CRC, MSB first
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// File: sv/cfe_front.sv
// ============================================================================
// cfe_front
// Accepts requests, holds the config registers and frame tracking, and
// turns each useful request into a job for the serializer.
// ============================================================================
module cfe_front
    import cfe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   q_full,
    output logic                   q_push,
    output job_t                   q_job
);

    logic [7:0]  version_reg;
    logic [15:0] preamble_reg;
    logic        in_frame_reg, in_frame_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic        accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg  <= VERSION_RESET;
            preamble_reg <= PREAMBLE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_VERSION:  version_reg  <= cfg_data[7:0];
                CFG_PREAMBLE: preamble_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Classify the request and build the job
    always_comb
    begin
        in_frame_next   = in_frame_reg;
        bytes_left_next = bytes_left_reg;
        q_push          = 1'b0;
        q_job.kind         = JOB_START;
        q_job.ends         = 1'b0;
        q_job.preamble     = preamble_reg;
        q_job.version      = version_reg;
        q_job.type_code    = in_data.type_code;
        q_job.seq_num      = in_data.seq_num;
        q_job.frame_length = in_data.frame_length;
        q_job.data         = in_data.payload_byte;
        if (accept)
        begin
            case (in_data.cmd)
                CMD_START:
                begin
                    // start mid-frame is dropped
                    if (!in_frame_reg)
                    begin
                        q_push          = 1'b1;
                        q_job.kind      = JOB_START;
                        q_job.ends      = (in_data.frame_length == 16'd0);
                        in_frame_next   = (in_data.frame_length != 16'd0);
                        bytes_left_next = in_data.frame_length;
                    end
                end
                CMD_PAYLOAD:
                begin
                    // stray payload outside a frame is dropped
                    if (in_frame_reg)
                    begin
                        q_push          = 1'b1;
                        q_job.kind      = JOB_DATA;
                        q_job.ends      = (bytes_left_reg == 16'd1);
                        bytes_left_next = bytes_left_reg - 16'd1;
                        in_frame_next   = (bytes_left_reg != 16'd1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= 16'd0;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

// File: sv/cfe_queue.sv
// ============================================================================
// cfe_queue
// Small job FIFO between the request front end and the byte serializer.
// ============================================================================
`include "crc16_frame_encoder_macros.svh"

module cfe_queue
    import cfe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == CNT_FULL);
    assign head_valid = (cnt_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    `CFE_ASSERT_IMP(a_no_push_full, clk, rst_n, push, !full)
    `CFE_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, head_valid)
    `CFE_ASSERT_NEXT(a_fill_grows, clk, rst_n, push && !pop, cnt_reg == $past(cnt_reg) + CNT_W'(1))

endmodule

// File: sv/cfe_back.sv
// ============================================================================
// cfe_back
// Serializes jobs to frame bytes, one per cycle unless stalled; keeps the CRC.
// ============================================================================
`include "crc16_frame_encoder_macros.svh"

module cfe_back
    import cfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  job_t      head_job,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic [POS_W-1:0] cnt_reg;
    logic [15:0]      crc_reg;
    logic             out_valid_reg;
    out_item_t        out_data_reg;

    logic [POS_W-1:0] cur_pos, last_pos;
    logic [7:0]       cur_byte;
    logic             advance, emit, is_last, crc_upd;
    logic [15:0]      crc_base;

    assign advance  = !out_valid_reg || !out_stall;
    assign emit     = head_valid && advance;
    // payload jobs enter at the data slot
    assign cur_pos  = (head_job.kind == JOB_DATA) ? POS_DATA + cnt_reg : cnt_reg;
    assign last_pos = head_job.ends ? POS_CRC_LO : POS_DATA;
    assign is_last  = (cur_pos == last_pos);
    assign pop      = emit && is_last;
    assign crc_upd  = (cur_pos >= POS_VERSION) && (cur_pos <= POS_DATA);
    assign crc_base = (cur_pos == POS_VERSION) ? CRC_INIT : crc_reg;

    // Byte select
    always_comb
    begin
        case (cur_pos)
            POS_PRE_HI:  cur_byte = head_job.preamble[15:8];
            POS_PRE_LO:  cur_byte = head_job.preamble[7:0];
            POS_VERSION: cur_byte = head_job.version;
            POS_TYPE:    cur_byte = head_job.type_code;
            POS_SEQ:     cur_byte = head_job.seq_num;
            POS_LEN_HI:  cur_byte = head_job.frame_length[15:8];
            POS_DATA:    cur_byte = (head_job.kind == JOB_START) ?
                                    head_job.frame_length[7:0] : head_job.data;
            POS_CRC_HI:  cur_byte = crc_reg[15:8];
            POS_CRC_LO:  cur_byte = crc_reg[7:0];
            default:     cur_byte = 8'h00;
        endcase
    end

    // Sequencer and CRC
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            crc_reg <= CRC_INIT;
        end
        else if (emit)
        begin
            cnt_reg <= is_last ? '0 : cnt_reg + POS_W'(1);
            if (crc_upd)
            begin
                crc_reg <= crc16_fold(crc_base, cur_byte);
            end
            else if (cur_pos == POS_CRC_LO)
            begin
                crc_reg <= CRC_INIT;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg.tx_byte   <= cur_byte;
            out_data_reg.run_last  <= is_last;
            out_data_reg.frame_end <= (cur_pos == POS_CRC_LO);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `CFE_ASSERT_IMP(a_end_is_last, clk, rst_n, out_valid_reg && out_data_reg.frame_end, out_data_reg.run_last)
    `CFE_ASSERT_IMP(a_pos_range, clk, rst_n, head_valid, cur_pos <= last_pos)
    `CFE_ASSERT_NEXT(a_seq_wrap, clk, rst_n, pop, cnt_reg == '0)

endmodule

// File: sv/crc16_frame_encoder.sv
// ============================================================================
// crc16_frame_encoder
// Serializes transmit frames (preamble, header, payload, CRC-16) as bytes.
// ============================================================================
// A start request (cmd 0) yields a frame head of 7 bytes: two preamble bytes
// and version, type, sequence, length high, length low; with a zero length
// the CRC follows at once for 9 bytes. Each payload request (cmd 1) yields
// its byte, plus the two CRC bytes (high first) when it is the last of the
// frame. Starts inside a frame and payload outside a frame are dropped.
// Requests are taken every cycle while the job queue (QUEUE_DEPTH entries)
// has room; the serializer emits one byte per cycle while out_stall is low,
// so throughput is set by the single output byte port. With the queue empty,
// a taken request passes the job queue and then the output register before
// its first byte appears.
// Config writes are always ready and apply to the next start.
`include "crc16_frame_encoder_macros.svh"

module crc16_frame_encoder
    import cfe_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic q_full, q_push, q_pop, q_head_valid;
    job_t q_job, q_head_job;

    cfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    cfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    cfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    `CFE_ASSERT_IMP(a_stall_only_full, clk, rst_n, in_stall, q_full)

endmodule
